// ===== rtl/dvnu_pkg.sv =====
// Shared types and constants of the distance vector node update engine.
package dvnu_pkg;

    localparam int COST_W = 16;
    localparam int NODE_W = 2;
    localparam int CFG_INDEX_W = 3;

    typedef logic [NODE_W-1:0] node_id_t;
    typedef logic [COST_W-1:0] cost_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_ELEMENT = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_OWN_NODE_ID = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_COST_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_COST_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_COST_2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_COST_3 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INFINITY_COST = 3'd5;

    typedef struct packed {
        logic     opcode;
        node_id_t source_node;
        node_id_t entry_index;
        cost_t    advertised_cost;
        logic     last_entry;
    } item_t;

    typedef struct packed {
        node_id_t dest_node;
        node_id_t vector_index;
        cost_t    route_cost;
        logic     last_of_packet;
        logic     last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ELEM_RD,
        ST_ELEM_WR,
        ST_MIN_RD,
        ST_MIN_CMP,
        ST_ANNOUNCE
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     load_vector;
        logic     tbl_rd;
        logic     rd_diag;
        logic     wr_init;
        logic     wr_sum;
        logic     clr_changed;
        logic     min_acc;
        logic     row_done;
        logic     out_load;
        node_id_t row;
        node_id_t col;
    } cmd_t;

    typedef struct packed {
        logic item_opcode;
        logic elem_last;
        logic elem_in_range;
        logic neighbor;
        logic out_free;
        logic changed;
    } status_t;

endpackage

// ===== rtl/dvnu_ctrl.sv =====
// Controller state machine and node counters of the distance vector engine.
module dvnu_ctrl
    import dvnu_pkg::*;
#(
    parameter int NODES = 4
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  status_t sts,
    output cmd_t    cmd
);

    localparam node_id_t LAST_NODE = node_id_t'(NODES - 1);

    state_t   state_reg, state_next;
    node_id_t row_reg, row_next;
    node_id_t col_reg, col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        item_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    row_next    = '0;
                    col_next    = '0;
                    if (sts.item_opcode == OP_START)
                    begin
                        cmd.load_vector = 1'b1;
                        state_next      = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_ELEM_RD;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.wr_init = 1'b1;
                if (col_reg == LAST_NODE)
                begin
                    col_next = '0;
                    if (row_reg == LAST_NODE)
                    begin
                        row_next   = '0;
                        state_next = ST_ANNOUNCE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_ELEM_RD:
            begin
                cmd.tbl_rd  = 1'b1;
                cmd.rd_diag = 1'b1;
                state_next  = ST_ELEM_WR;
            end
            ST_ELEM_WR:
            begin
                cmd.wr_sum = sts.elem_in_range;
                if (sts.elem_last)
                begin
                    cmd.clr_changed = 1'b1;
                    state_next      = ST_MIN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MIN_RD:
            begin
                cmd.tbl_rd = 1'b1;
                state_next = ST_MIN_CMP;
            end
            ST_MIN_CMP:
            begin
                cmd.min_acc = 1'b1;
                state_next  = ST_MIN_RD;
                if (col_reg == LAST_NODE)
                begin
                    cmd.row_done = 1'b1;
                    col_next     = '0;
                    if (row_reg == LAST_NODE)
                    begin
                        row_next   = '0;
                        state_next = sts.changed ? ST_ANNOUNCE : ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_ANNOUNCE:
            begin
                if (!sts.neighbor || sts.out_free)
                begin
                    cmd.out_load = sts.neighbor;
                    if (!sts.neighbor || col_reg == LAST_NODE)
                    begin
                        col_next = '0;
                        if (row_reg == LAST_NODE)
                        begin
                            row_next   = '0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_elem_not_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ELEM_WR && !sts.elem_last) |=> (state_reg == ST_IDLE))
        else $error("element without last mark did not return to idle");

    a_start_enters_init: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && sts.item_opcode == OP_START) |=>
        (state_reg == ST_INIT && row_reg == '0 && col_reg == '0))
        else $error("start transaction did not begin the table sweep");

endmodule

// ===== rtl/dvnu_dp.sv =====
// Datapath of the distance vector engine: registers, cost table, minimum and output stage.
module dvnu_dp
    import dvnu_pkg::*;
#(
    parameter int NODES = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  cost_t                  cfg_data,
    input  item_t                  item,
    input  logic                   result_stall,
    output logic                   result_valid,
    output result_t                result,
    input  cmd_t                   cmd,
    output status_t                sts
);

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int TBL_DEPTH = NODES * NODES;
    localparam int AW = $clog2(TBL_DEPTH);
    localparam node_id_t LAST_NODE = node_id_t'(NODES - 1);

    node_id_t own_id_reg;
    cost_t    link_reg [4];
    cost_t    inf_reg;

    item_t    item_reg;
    cost_t    av_reg [NODES];
    cost_t    min_reg;
    logic     changed_reg;
    cost_t    tbl_mem [TBL_DEPTH];
    cost_t    rd_data_reg;

    logic     out_valid_reg, out_valid_next;
    result_t  out_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    cost_t         wr_data;
    logic          tbl_we;
    logic [COST_W:0] sum;
    cost_t         sum_sat;
    cost_t         min_cand;
    logic          elig [NODES];
    logic          later_elig;
    logic          out_free;

    function automatic cost_t link_of(input node_id_t n, input cost_t l0, input cost_t l1,
                                      input cost_t l2, input cost_t l3);
        cost_t v;
        unique case (n)
            2'd0: v = l0;
            2'd1: v = l1;
            2'd2: v = l2;
            default: v = l3;
        endcase
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg  <= 2'd3;
            link_reg[0] <= 16'd9999;
            link_reg[1] <= 16'd9999;
            link_reg[2] <= 16'd9999;
            link_reg[3] <= 16'd0;
            inf_reg     <= 16'd9999;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_NODE_ID:   own_id_reg  <= cfg_data[NODE_W-1:0];
                REG_LINK_COST_0:   link_reg[0] <= cfg_data;
                REG_LINK_COST_1:   link_reg[1] <= cfg_data;
                REG_LINK_COST_2:   link_reg[2] <= cfg_data;
                REG_LINK_COST_3:   link_reg[3] <= cfg_data;
                REG_INFINITY_COST: inf_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        later_elig = 1'b0;
        for (int m = 0; m < NODES; m++)
        begin
            elig[m] = (node_id_t'(m) != own_id_reg) &&
                      (link_of(node_id_t'(m), link_reg[0], link_reg[1], link_reg[2],
                               link_reg[3]) < inf_reg);
            if (node_id_t'(m) > cmd.row && elig[m])
            begin
                later_elig = 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_addr = cmd.rd_diag
            ? AW'(int'(item_reg.source_node) * NODES + int'(item_reg.source_node))
            : AW'(int'(cmd.row) * NODES + int'(cmd.col));
        wr_addr = cmd.wr_init
            ? AW'(int'(cmd.row) * NODES + int'(cmd.col))
            : AW'(int'(item_reg.entry_index) * NODES + int'(item_reg.source_node));
        sum     = {1'b0, rd_data_reg} + {1'b0, item_reg.advertised_cost};
        sum_sat = (sum > {1'b0, inf_reg}) ? inf_reg : sum[COST_W-1:0];
        if (cmd.wr_init)
        begin
            wr_data = (cmd.row == cmd.col)
                ? link_of(cmd.col, link_reg[0], link_reg[1], link_reg[2], link_reg[3])
                : inf_reg;
        end
        else
        begin
            wr_data = sum_sat;
        end
        tbl_we   = cmd.wr_init || cmd.wr_sum;
        min_cand = (cmd.col == '0 || rd_data_reg < min_reg) ? rd_data_reg : min_reg;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
        if (cmd.tbl_rd)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.min_acc)
        begin
            min_reg <= min_cand;
        end
        for (int i = 0; i < NODES; i++)
        begin
            if (cmd.load_vector)
            begin
                av_reg[i] <= (node_id_t'(i) == own_id_reg) ? '0
                    : link_of(node_id_t'(i), link_reg[0], link_reg[1], link_reg[2],
                              link_reg[3]);
            end
            else if (cmd.row_done && cmd.row[NW-1:0] == NW'(i))
            begin
                av_reg[i] <= min_cand;
            end
        end
        if (cmd.out_load)
        begin
            out_reg.dest_node      <= cmd.row;
            out_reg.vector_index   <= cmd.col;
            out_reg.route_cost     <= av_reg[cmd.col[NW-1:0]];
            out_reg.last_of_packet <= (cmd.col == LAST_NODE);
            out_reg.last           <= (cmd.col == LAST_NODE) && !later_elig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_changed)
            begin
                changed_reg <= 1'b0;
            end
            else if (cmd.row_done)
            begin
                changed_reg <= sts.changed;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || !result_stall;
        out_valid_next = cmd.out_load ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
        result_valid   = out_valid_reg;
        result         = out_reg;

        sts.item_opcode   = item.opcode;
        sts.elem_last     = item_reg.last_entry;
        sts.elem_in_range = (int'(item_reg.source_node) < NODES) &&
                            (int'(item_reg.entry_index) < NODES);
        sts.neighbor      = elig[cmd.row[NW-1:0]];
        sts.out_free      = out_free;
        sts.changed       = changed_reg || (min_cand != av_reg[cmd.row[NW-1:0]]);
    end

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !result_stall))
        else $error("output register loaded while holding a stalled transaction");

    a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> result.last_of_packet)
        else $error("final result does not close a packet");

endmodule

// ===== rtl/distance_vector_node_update.sv =====
// Top level of the distance vector node update engine.
//
//   channel   direction  handshake              payload
//   item      in         item_valid/item_stall  item_t (opcode, source, index, cost, last)
//   result    out        result_valid/stall     result_t (dest, index, cost, last marks)
//   cfg       in         cfg_we                 cfg_index, cfg_data
//
// A start transaction sweeps the cost table, then skips each node that is no neighbour
// and sends each vector element to the others, slower when the result side stalls.
// A vector element is read, summed and written back; one marked last adds the row
// minimum walk over the table, plus the announcement when the vector changed. Reset
// clears control state and loads the register defaults; the cost table holds nothing
// meaningful until a start. A result waits in its register under stall.
module distance_vector_node_update
    import dvnu_pkg::*;
#(
    parameter int NODES = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  cost_t                  cfg_data,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    cmd_t    cmd;
    status_t sts;

    dvnu_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    dvnu_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
